// File: rtl/pbpa_pkg.sv
// ----------------------------------------------------------------------------
// pbpa_pkg
// Shared widths, register indexes and control structures for the Parisian
// barrier payoff accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package pbpa_pkg;

  // Counter widths.
  localparam int DAY_BITS       = 12;
  localparam int PATH_BITS      = 16;
  localparam int PATH_MAX_BITS  = 24;
  localparam int CFG_DAY_BITS   = 12;
  localparam int CMP_BITS       = (DAY_BITS > CFG_DAY_BITS) ? DAY_BITS : CFG_DAY_BITS;

  // Data widths.
  localparam int PRICE_BITS     = 32;
  localparam int SUM_BITS       = 48;
  localparam int RESULT_BITS    = 32;
  localparam int COUNT_BITS     = 16;
  localparam int DF_BITS        = 17;
  localparam int DF_FRAC_BITS   = 16;
  localparam logic [DF_BITS-1:0] DF_ONE = DF_BITS'(65536);
  localparam logic [CFG_DAY_BITS-1:0] PAYOFF_DAY_RESET = CFG_DAY_BITS'(364);

  // Mean is split into a low and a high part for the 32x16 multiplier.
  localparam int MEAN_LO_BITS   = 32;
  localparam int MEAN_HI_BITS   = SUM_BITS - MEAN_LO_BITS;
  localparam int PROD_LO_BITS   = MEAN_LO_BITS + DF_FRAC_BITS;
  localparam int PROD_HI_BITS   = MEAN_HI_BITS + DF_FRAC_BITS;
  localparam int TOTAL_BITS     = SUM_BITS + DF_FRAC_BITS;

  // Eight sums in output order.
  localparam int NUM_SUMS       = 8;
  localparam int SEL_BITS       = $clog2(NUM_SUMS);
  localparam int STEP_BITS      = $clog2(SUM_BITS);

  // Streaming payload widths.
  localparam int OUT_FIELD_BITS = NUM_SUMS * RESULT_BITS + COUNT_BITS + 1;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
  localparam int IN_DATA_BITS   = PRICE_BITS;

  // Configuration port.
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_BARRIER_LEVEL   = 3'd0,
    REG_STRIKE_PRICE    = 3'd1,
    REG_ACTIVATION_DAYS = 3'd2,
    REG_PAYOFF_DAY      = 3'd3,
    REG_DISCOUNT_FACTOR = 3'd4
  } cfg_reg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                load;
    logic                div_step;
    logic                mul_lo;
    logic                mul_hi;
    logic                store;
    logic                emit;
    logic [SEL_BITS-1:0] sel;
  } pbpa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic acc_busy;
    logic out_valid;
  } pbpa_stat_t;

endpackage

`default_nettype wire

// File: rtl/pbpa_ctrl.sv
// ----------------------------------------------------------------------------
// pbpa_ctrl
// Controller: runs the sample phase and sequences the end-of-run scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module pbpa_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 take,
  input  wire logic                 close_run,
  input  wire pbpa_pkg::pbpa_stat_t stat,
  output      logic                 in_ready,
  output      pbpa_pkg::pbpa_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_RUN,
    ST_DRAIN,
    ST_LOAD,
    ST_DIV,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_STORE,
    ST_EMIT
  } state_t;

  localparam logic [pbpa_pkg::STEP_BITS-1:0] LAST_STEP =
    pbpa_pkg::STEP_BITS'(pbpa_pkg::SUM_BITS - 1);
  localparam logic [pbpa_pkg::SEL_BITS-1:0] LAST_SEL =
    pbpa_pkg::SEL_BITS'(pbpa_pkg::NUM_SUMS - 1);

  state_t                         state;
  logic [pbpa_pkg::STEP_BITS-1:0] step;
  logic [pbpa_pkg::SEL_BITS-1:0]  sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
      step  <= '0;
      sel   <= '0;
    end else begin
      case (state)
        ST_RUN: begin
          if (take && close_run) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          // The path pipeline must settle and the previous result be taken.
          if (!stat.acc_busy && !stat.out_valid) begin
            state <= ST_LOAD;
            sel   <= '0;
          end
        end
        ST_LOAD: begin
          state <= ST_DIV;
          step  <= '0;
        end
        ST_DIV: begin
          if (step == LAST_STEP) begin
            state <= ST_MUL_LO;
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_MUL_LO: state <= ST_MUL_HI;
        ST_MUL_HI: state <= ST_STORE;
        ST_STORE: begin
          if (sel == LAST_SEL) begin
            state <= ST_EMIT;
          end else begin
            sel   <= sel + 1'b1;
            state <= ST_LOAD;
          end
        end
        ST_EMIT: state <= ST_RUN;
        default: state <= ST_RUN;
      endcase
    end
  end

  always_comb begin
    in_ready     = (state == ST_RUN);
    cmd.load     = (state == ST_LOAD);
    cmd.div_step = (state == ST_DIV);
    cmd.mul_lo   = (state == ST_MUL_LO);
    cmd.mul_hi   = (state == ST_MUL_HI);
    cmd.store    = (state == ST_STORE);
    cmd.emit     = (state == ST_EMIT);
    cmd.sel      = sel;
  end

endmodule

`default_nettype wire

// File: rtl/pbpa_acc.sv
// ----------------------------------------------------------------------------
// pbpa_acc
// Per-path counters, payoff capture and the eight saturating payoff sums.
// ----------------------------------------------------------------------------
`default_nettype none

module pbpa_acc (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  take,
  input  wire logic [pbpa_pkg::PRICE_BITS-1:0]       price,
  input  wire logic                                  path_end,
  input  wire logic [pbpa_pkg::PRICE_BITS-1:0]       barrier_level,
  input  wire logic [pbpa_pkg::PRICE_BITS-1:0]       strike_price,
  input  wire logic [pbpa_pkg::CFG_DAY_BITS-1:0]     activation_days,
  input  wire logic [pbpa_pkg::CFG_DAY_BITS-1:0]     payoff_day,
  input  wire pbpa_pkg::pbpa_cmd_t                   cmd,
  output      logic [pbpa_pkg::SUM_BITS-1:0]         sel_sum,
  output      logic [pbpa_pkg::PATH_BITS-1:0]        divisor,
  output      logic [pbpa_pkg::COUNT_BITS-1:0]       path_count,
  output      logic                                  short_seen,
  output      logic                                  busy
);

  localparam logic [pbpa_pkg::DAY_BITS-1:0]  DAY_SAT  = '1;
  localparam logic [pbpa_pkg::PATH_BITS-1:0] PATH_SAT = '1;

  // Per-path state.
  logic [pbpa_pkg::DAY_BITS-1:0]   day_index, days_above, days_below;
  logic [pbpa_pkg::PRICE_BITS-1:0] payoff_price;
  logic                            payoff_captured;

  logic [pbpa_pkg::DAY_BITS-1:0]   days_above_next, days_below_next, day_index_next;
  logic [pbpa_pkg::PRICE_BITS-1:0] payoff_price_next;
  logic                            payoff_captured_next;
  logic                            capture_hit;

  // Close stage: final counts of a finished path.
  logic                            close_valid;
  logic [pbpa_pkg::DAY_BITS-1:0]   close_above, close_below;
  logic [pbpa_pkg::PRICE_BITS-1:0] close_price;
  logic                            close_captured;

  // Post stage: amount and the two target sums.
  logic                            post_valid;
  logic [pbpa_pkg::PRICE_BITS-1:0] post_amount;
  logic [pbpa_pkg::SEL_BITS-1:0]   post_up_sel, post_down_sel;

  logic                            is_call, up_on, down_on;
  logic [pbpa_pkg::PRICE_BITS-1:0] amount;

  // Run totals.
  logic [pbpa_pkg::SUM_BITS-1:0]   payoff_sums [pbpa_pkg::NUM_SUMS];
  logic [pbpa_pkg::PATH_BITS-1:0]  path_total;
  logic                            short_flag;

  logic [pbpa_pkg::PATH_MAX_BITS-1:0] path_wide;

  always_comb begin
    days_above_next = days_above;
    days_below_next = days_below;
    if (price > barrier_level) begin
      days_above_next = (days_above == DAY_SAT) ? DAY_SAT : days_above + 1'b1;
    end else begin
      days_below_next = (days_below == DAY_SAT) ? DAY_SAT : days_below + 1'b1;
    end
    capture_hit = !payoff_captured &&
                  (pbpa_pkg::CMP_BITS'(day_index) == pbpa_pkg::CMP_BITS'(payoff_day));
    payoff_price_next    = capture_hit ? price : payoff_price;
    payoff_captured_next = payoff_captured || capture_hit;
    day_index_next       = (day_index == DAY_SAT) ? DAY_SAT : day_index + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      day_index       <= '0;
      days_above      <= '0;
      days_below      <= '0;
      payoff_price    <= '0;
      payoff_captured <= 1'b0;
      close_valid     <= 1'b0;
    end else begin
      close_valid <= take && path_end;
      if (take) begin
        if (path_end) begin
          day_index       <= '0;
          days_above      <= '0;
          days_below      <= '0;
          payoff_price    <= '0;
          payoff_captured <= 1'b0;
        end else begin
          day_index       <= day_index_next;
          days_above      <= days_above_next;
          days_below      <= days_below_next;
          payoff_price    <= payoff_price_next;
          payoff_captured <= payoff_captured_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && path_end) begin
      close_above    <= days_above_next;
      close_below    <= days_below_next;
      close_price    <= payoff_price_next;
      close_captured <= payoff_captured_next;
    end
  end

  always_comb begin
    up_on   = pbpa_pkg::CMP_BITS'(close_above) > pbpa_pkg::CMP_BITS'(activation_days);
    down_on = pbpa_pkg::CMP_BITS'(close_below) > pbpa_pkg::CMP_BITS'(activation_days);
    is_call = close_price > strike_price;
    amount  = is_call ? (close_price - strike_price) : (strike_price - close_price);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      post_valid <= 1'b0;
      path_total <= '0;
      short_flag <= 1'b0;
    end else begin
      post_valid <= close_valid && close_captured;
      if (cmd.emit) begin
        path_total <= '0;
        short_flag <= 1'b0;
      end else if (close_valid) begin
        path_total <= (path_total == PATH_SAT) ? PATH_SAT : path_total + 1'b1;
        if (!close_captured) begin
          short_flag <= 1'b1;
        end
      end
    end
  end

  // Calls use sums zero to three, puts four to seven; out sums are the odd ones.
  always_ff @(posedge clk) begin
    if (close_valid) begin
      post_amount   <= amount;
      post_up_sel   <= {!is_call, 1'b0, !up_on};
      post_down_sel <= {!is_call, 1'b1, !down_on};
    end
  end

  always_ff @(posedge clk) begin
    logic [pbpa_pkg::SUM_BITS:0] grown;
    if (rst || cmd.emit) begin
      for (int k = 0; k < pbpa_pkg::NUM_SUMS; k++) begin
        payoff_sums[k] <= '0;
      end
    end else if (post_valid) begin
      for (int k = 0; k < pbpa_pkg::NUM_SUMS; k++) begin
        grown = {1'b0, payoff_sums[k]} + (pbpa_pkg::SUM_BITS + 1)'(post_amount);
        if (pbpa_pkg::SEL_BITS'(k) == post_up_sel ||
            pbpa_pkg::SEL_BITS'(k) == post_down_sel) begin
          payoff_sums[k] <= grown[pbpa_pkg::SUM_BITS] ? '1 : grown[pbpa_pkg::SUM_BITS-1:0];
        end
      end
    end
  end

  always_comb begin
    sel_sum    = payoff_sums[cmd.sel];
    divisor    = (path_total == '0) ? pbpa_pkg::PATH_BITS'(1) : path_total;
    path_wide  = pbpa_pkg::PATH_MAX_BITS'(path_total);
    path_count = (path_wide > pbpa_pkg::PATH_MAX_BITS'(16'hFFFF)) ?
                 '1 : path_wide[pbpa_pkg::COUNT_BITS-1:0];
    short_seen = short_flag;
    busy       = close_valid || post_valid;
  end

endmodule

`default_nettype wire

// File: rtl/pbpa_scale.sv
// ----------------------------------------------------------------------------
// pbpa_scale
// Bit-serial divider, shared 32x16 multiplier and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module pbpa_scale (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire pbpa_pkg::pbpa_cmd_t                   cmd,
  input  wire logic [pbpa_pkg::SUM_BITS-1:0]         dividend,
  input  wire logic [pbpa_pkg::PATH_BITS-1:0]        divisor,
  input  wire logic [pbpa_pkg::DF_BITS-1:0]          discount_factor,
  input  wire logic [pbpa_pkg::COUNT_BITS-1:0]       path_count,
  input  wire logic                                  short_seen,
  input  wire logic                                  out_ready,
  output      logic                                  out_valid,
  output      logic [pbpa_pkg::RESULT_BITS-1:0]      results [pbpa_pkg::NUM_SUMS],
  output      logic [pbpa_pkg::COUNT_BITS-1:0]       paths_counted,
  output      logic                                  short_path_seen
);

  logic [pbpa_pkg::SUM_BITS-1:0]       quo;
  logic [pbpa_pkg::PATH_BITS-1:0]      rem;
  logic [pbpa_pkg::PATH_BITS:0]        trial;
  logic                                fits;

  logic [pbpa_pkg::DF_BITS-1:0]        df_eff;
  logic                                df_full;
  logic [pbpa_pkg::DF_FRAC_BITS-1:0]   df_frac;
  logic [pbpa_pkg::MEAN_LO_BITS-1:0]   mul_a;
  logic [pbpa_pkg::PROD_LO_BITS-1:0]   product;
  logic [pbpa_pkg::PROD_LO_BITS-1:0]   prod_lo;
  logic [pbpa_pkg::PROD_HI_BITS-1:0]   prod_hi;
  logic [pbpa_pkg::TOTAL_BITS-1:0]     total;
  logic [pbpa_pkg::SUM_BITS-1:0]       scaled;

  always_comb begin
    trial   = {rem, quo[pbpa_pkg::SUM_BITS-1]};
    fits    = trial >= {1'b0, divisor};
    df_eff  = (discount_factor > pbpa_pkg::DF_ONE) ? pbpa_pkg::DF_ONE : discount_factor;
    df_full = df_eff[pbpa_pkg::DF_BITS-1];
    df_frac = df_eff[pbpa_pkg::DF_FRAC_BITS-1:0];
    mul_a   = cmd.mul_lo ? quo[pbpa_pkg::MEAN_LO_BITS-1:0] :
              pbpa_pkg::MEAN_LO_BITS'(quo[pbpa_pkg::SUM_BITS-1:pbpa_pkg::MEAN_LO_BITS]);
    product = pbpa_pkg::PROD_LO_BITS'(mul_a) * pbpa_pkg::PROD_LO_BITS'(df_frac);
    total   = {prod_hi, {pbpa_pkg::MEAN_LO_BITS{1'b0}}} +
              pbpa_pkg::TOTAL_BITS'(prod_lo);
    scaled  = df_full ? quo : total[pbpa_pkg::TOTAL_BITS-1:pbpa_pkg::DF_FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo <= dividend;
      rem <= '0;
    end else if (cmd.div_step) begin
      quo <= {quo[pbpa_pkg::SUM_BITS-2:0], fits};
      rem <= fits ? pbpa_pkg::PATH_BITS'(trial - {1'b0, divisor}) :
                    trial[pbpa_pkg::PATH_BITS-1:0];
    end
    if (cmd.mul_lo) begin
      prod_lo <= product;
    end
    if (cmd.mul_hi) begin
      prod_hi <= product[pbpa_pkg::PROD_HI_BITS-1:0];
    end
    if (cmd.store) begin
      results[cmd.sel] <= (|scaled[pbpa_pkg::SUM_BITS-1:pbpa_pkg::RESULT_BITS]) ?
                          '1 : scaled[pbpa_pkg::RESULT_BITS-1:0];
    end
    if (cmd.emit) begin
      paths_counted   <= path_count;
      short_path_seen <= short_seen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: rtl/parisian_barrier_payoff_accumulator_unit.sv
// ----------------------------------------------------------------------------
// parisian_barrier_payoff_accumulator_unit
// Accumulates Parisian barrier option payoffs over simulated price paths and
// emits the eight discounted mean payoffs at the end of each run.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Request contents
//  --------  ---------  -----------------------------------------------------
//  s_axis    in         price_sample (tdata), end_of_path (tlast),
//                       end_of_run (tuser)
//  m_axis    out        eight discounted means, paths_counted, short_path_seen
//  cfg       in         register index and write data, no read-back
//
//  A price sample is taken every cycle while a run is in progress; the path
//  bookkeeping runs in a two-stage pipeline behind the sample counters.
//  A request that carries both end_of_path and end_of_run drops s_axis_tready
//  until the result is emitted, also over any wait for the previous result to
//  be taken. The pipeline settles first, sooner when the closing path is short;
//  then each sum takes a load, SUM_BITS divider steps at one quotient bit per
//  cycle, a low and a high multiplier step and a store; an emit step then
//  presents the result. The result then sits in its output register while new
//  samples are accepted. Reset is synchronous and restores the register
//  defaults and clears all sums and counters.
//
`default_nettype none

module parisian_barrier_payoff_accumulator_unit (
  input  wire logic                                  clk,
  input  wire logic                                  rst,

  // tdata: price_sample[31:0]
  input  wire logic [pbpa_pkg::IN_DATA_BITS-1:0]     s_axis_tdata,
  input  wire logic                                  s_axis_tlast,
  // tuser: end_of_run[0]
  input  wire logic                                  s_axis_tuser,
  input  wire logic                                  s_axis_tvalid,
  output      logic                                  s_axis_tready,

  // tdata: call_up_in[31:0], call_up_out[63:32], call_down_in[95:64],
  // call_down_out[127:96], put_up_in[159:128], put_up_out[191:160],
  // put_down_in[223:192], put_down_out[255:224], paths_counted[271:256],
  // short_path_seen[272], zero fill up to bit 279
  output      logic [pbpa_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata,
  output      logic                                  m_axis_tvalid,
  input  wire logic                                  m_axis_tready,

  input  wire logic                                  cfg_we,
  input  wire logic [pbpa_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [pbpa_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  // Configuration registers.
  logic [pbpa_pkg::PRICE_BITS-1:0]   barrier_level;
  logic [pbpa_pkg::PRICE_BITS-1:0]   strike_price;
  logic [pbpa_pkg::CFG_DAY_BITS-1:0] activation_days;
  logic [pbpa_pkg::CFG_DAY_BITS-1:0] payoff_day;
  logic [pbpa_pkg::DF_BITS-1:0]      discount_factor;

  pbpa_pkg::pbpa_cmd_t  cmd;
  pbpa_pkg::pbpa_stat_t stat;

  logic                               take;
  logic                               acc_busy;
  logic                               out_valid;
  logic [pbpa_pkg::SUM_BITS-1:0]      sel_sum;
  logic [pbpa_pkg::PATH_BITS-1:0]     divisor;
  logic [pbpa_pkg::COUNT_BITS-1:0]    path_count;
  logic                               short_seen;
  logic [pbpa_pkg::RESULT_BITS-1:0]   results [pbpa_pkg::NUM_SUMS];
  logic [pbpa_pkg::COUNT_BITS-1:0]    paths_counted;
  logic                               short_path_seen;

  // Writes to indexes beyond the register list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      barrier_level   <= '0;
      strike_price    <= '0;
      activation_days <= '0;
      payoff_day      <= pbpa_pkg::PAYOFF_DAY_RESET;
      discount_factor <= pbpa_pkg::DF_ONE;
    end else if (cfg_we) begin
      case (cfg_index)
        pbpa_pkg::REG_BARRIER_LEVEL:   barrier_level   <= cfg_data;
        pbpa_pkg::REG_STRIKE_PRICE:    strike_price    <= cfg_data;
        pbpa_pkg::REG_ACTIVATION_DAYS:
          activation_days <= cfg_data[pbpa_pkg::CFG_DAY_BITS-1:0];
        pbpa_pkg::REG_PAYOFF_DAY:
          payoff_day      <= cfg_data[pbpa_pkg::CFG_DAY_BITS-1:0];
        pbpa_pkg::REG_DISCOUNT_FACTOR:
          discount_factor <= cfg_data[pbpa_pkg::DF_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign take           = s_axis_tvalid && s_axis_tready;
  assign stat.acc_busy  = acc_busy;
  assign stat.out_valid = out_valid;

  pbpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .close_run (s_axis_tlast && s_axis_tuser),
    .stat      (stat),
    .in_ready  (s_axis_tready),
    .cmd       (cmd)
  );

  pbpa_acc u_acc (
    .clk             (clk),
    .rst             (rst),
    .take            (take),
    .price           (s_axis_tdata),
    .path_end        (s_axis_tlast),
    .barrier_level   (barrier_level),
    .strike_price    (strike_price),
    .activation_days (activation_days),
    .payoff_day      (payoff_day),
    .cmd             (cmd),
    .sel_sum         (sel_sum),
    .divisor         (divisor),
    .path_count      (path_count),
    .short_seen      (short_seen),
    .busy            (acc_busy)
  );

  pbpa_scale u_scale (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .dividend        (sel_sum),
    .divisor         (divisor),
    .discount_factor (discount_factor),
    .path_count      (path_count),
    .short_seen      (short_seen),
    .out_ready       (m_axis_tready),
    .out_valid       (out_valid),
    .results         (results),
    .paths_counted   (paths_counted),
    .short_path_seen (short_path_seen)
  );

  // The result register is held until the downstream side takes it.
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {
    {(pbpa_pkg::OUT_DATA_BITS - pbpa_pkg::OUT_FIELD_BITS){1'b0}},
    short_path_seen, paths_counted,
    results[7], results[6], results[5], results[4],
    results[3], results[2], results[1], results[0]
  };

endmodule

`default_nettype wire

// File: rtl/pbpa_checker.sv
// ----------------------------------------------------------------------------
// pbpa_checker
// Port-level checks on the payoff accumulator, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pbpa_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               s_axis_tvalid,
  input wire logic                               s_axis_tready,
  input wire logic                               s_axis_tlast,
  input wire logic                               s_axis_tuser,
  input wire logic                               m_axis_tvalid,
  input wire logic                               m_axis_tready,
  input wire logic [pbpa_pkg::OUT_DATA_BITS-1:0] m_axis_tdata
);

  // A stalled result stays put.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Closing a run stops the sample stream at once.
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast && s_axis_tuser |=> !s_axis_tready)
    else $error("samples accepted after end of run");

  // A result only appears out of the end-of-run phase.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result emitted while sampling");

  // Every run holds at least one path.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[271:256] != 16'd0)
    else $error("result with zero paths");

endmodule

bind parisian_barrier_payoff_accumulator_unit pbpa_checker u_pbpa_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// File: tb/tb_parisian_barrier_payoff_accumulator_unit.sv
// ----------------------------------------------------------------------------
// tb_parisian_barrier_payoff_accumulator_unit
// Self-checking bench for the Parisian barrier payoff accumulator. Price
// samples are streamed in with random gaps, a sample-level predictor tracks
// the per-path counters and the eight payoff sums, and every end-of-run
// result is compared field by field with the predicted discounted means.
// ----------------------------------------------------------------------------
module tb_parisian_barrier_payoff_accumulator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // Longest legitimate quiet spell is the receiver freeze plus the divider,
  // so the watchdog allows ten times that.
  localparam int WATCHDOG_LIMIT   = 20000;
  localparam int SETTLE_CYCLES    = 40;
  localparam int RX_FREEZE_CYCLES = 1500;
  localparam int RANDOM_TARGET    = 1000;
  localparam int MIN_RANDOM_RUNS  = 40;
  localparam int PHASE_ITEMS      = 170;
  localparam int CALM_PHASE       = 4;
  localparam int MAX_PRINTED      = 100;

  localparam logic [pbpa_pkg::DAY_BITS-1:0]  DAY_TOP  = '1;
  localparam logic [pbpa_pkg::PATH_BITS-1:0] PATH_TOP = '1;
  localparam logic [pbpa_pkg::SUM_BITS-1:0]  SUM_TOP  = '1;

  // Sum layout: calls first, puts from PUT_BASE; up pair then down pair;
  // knock-in before knock-out within each pair.
  localparam int PUT_BASE    = 4;
  localparam int DOWN_OFFSET = 2;
  localparam int OUT_OFFSET  = 1;

  typedef struct packed {
    logic                            run_end;
    logic                            path_end;
    logic [pbpa_pkg::PRICE_BITS-1:0] price;
  } sample_req_t;

  // Same bit layout as the result tdata, lowest field in the lowest bits.
  typedef struct packed {
    logic                                                      short_seen;
    logic [pbpa_pkg::COUNT_BITS-1:0]                           paths;
    logic [pbpa_pkg::NUM_SUMS-1:0][pbpa_pkg::RESULT_BITS-1:0]  mean_pay;
  } payoff_report_t;

  localparam int REPORT_BITS = $bits(payoff_report_t);

  string sum_names [pbpa_pkg::NUM_SUMS] = '{"call_up_in", "call_up_out", "call_down_in",
                                            "call_down_out", "put_up_in", "put_up_out",
                                            "put_down_in", "put_down_out"};

  // --------------------------------------------------------------------------
  // Clock, reset and the block's ports. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic [pbpa_pkg::IN_DATA_BITS-1:0]   s_axis_tdata  = '0;
  logic                                s_axis_tlast  = 1'b0;
  logic                                s_axis_tuser  = 1'b0;
  logic                                s_axis_tvalid = 1'b0;
  logic                                s_axis_tready;
  logic [pbpa_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata;
  logic                                m_axis_tvalid;
  logic                                m_axis_tready = 1'b0;
  logic                                cfg_we        = 1'b0;
  logic [pbpa_pkg::CFG_INDEX_BITS-1:0] cfg_index     = pbpa_pkg::REG_BARRIER_LEVEL;
  logic [pbpa_pkg::CFG_DATA_BITS-1:0]  cfg_data      = '0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  parisian_barrier_payoff_accumulator_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Shared bench state.
  // --------------------------------------------------------------------------
  sample_req_t    pending_samples [$];
  payoff_report_t expected_reports [$];

  logic in_fire  = 1'b0;   // a sample request was taken at the last rising edge
  bit   calm     = 1'b0;   // suppresses random idling on both sides
  int   freeze_requests = 0;
  int   freeze_seen     = 0;
  int   freeze_left     = 0;
  int   quiet_cycles    = 0;
  int   mismatch_count  = 0;
  int   samples_taken   = 0;
  int   reports_checked = 0;

  // --------------------------------------------------------------------------
  // Predictor: its own copy of the registers and of the accumulator state.
  // --------------------------------------------------------------------------
  logic [pbpa_pkg::PRICE_BITS-1:0]   cfg_barrier;
  logic [pbpa_pkg::PRICE_BITS-1:0]   cfg_strike;
  logic [pbpa_pkg::CFG_DAY_BITS-1:0] cfg_act_days;
  logic [pbpa_pkg::CFG_DAY_BITS-1:0] cfg_payoff_day;
  logic [pbpa_pkg::DF_BITS-1:0]      cfg_discount;

  logic [pbpa_pkg::DAY_BITS-1:0]     day_idx;
  logic [pbpa_pkg::DAY_BITS-1:0]     above_cnt;
  logic [pbpa_pkg::DAY_BITS-1:0]     below_cnt;
  logic [pbpa_pkg::PRICE_BITS-1:0]   maturity_price;
  logic                              maturity_seen;
  logic [pbpa_pkg::SUM_BITS-1:0]     payoff_sum [pbpa_pkg::NUM_SUMS];
  logic [pbpa_pkg::PATH_BITS-1:0]    path_cnt;
  logic                              short_path_flag;

  function automatic void clear_path_state();
    day_idx        = '0;
    above_cnt      = '0;
    below_cnt      = '0;
    maturity_price = '0;
    maturity_seen  = 1'b0;
  endfunction

  function automatic void clear_batch_state();
    for (int k = 0; k < pbpa_pkg::NUM_SUMS; k++) payoff_sum[k] = '0;
    path_cnt        = '0;
    short_path_flag = 1'b0;
  endfunction

  function automatic logic [pbpa_pkg::SUM_BITS-1:0] sat_add(
      input logic [pbpa_pkg::SUM_BITS-1:0]   acc,
      input logic [pbpa_pkg::PRICE_BITS-1:0] amount);
    logic [pbpa_pkg::SUM_BITS:0] grown;
    grown = {1'b0, acc} + (pbpa_pkg::SUM_BITS + 1)'(amount);
    return grown[pbpa_pkg::SUM_BITS] ? SUM_TOP : grown[pbpa_pkg::SUM_BITS-1:0];
  endfunction

  // Advances the predictor by one accepted sample. Returns 1 when the sample
  // closes a run, with the expected result in rpt.
  function automatic bit absorb_sample(input sample_req_t req, output payoff_report_t rpt);
    logic                                              up_on;
    logic                                              down_on;
    logic                                              is_call;
    int                                                base;
    logic [pbpa_pkg::PRICE_BITS-1:0]                   amount;
    logic [pbpa_pkg::DF_BITS-1:0]                      df_eff;
    logic [pbpa_pkg::SUM_BITS-1:0]                     mean;
    logic [pbpa_pkg::SUM_BITS+pbpa_pkg::DF_BITS-1:0]   scaled;
    logic [pbpa_pkg::SUM_BITS+pbpa_pkg::DF_BITS-1:0]   shifted;
    rpt = '0;

    // A tie with the barrier counts as a day below.
    if (req.price > cfg_barrier) begin
      if (above_cnt != DAY_TOP) above_cnt++;
    end else begin
      if (below_cnt != DAY_TOP) below_cnt++;
    end
    if (!maturity_seen && day_idx == cfg_payoff_day) begin
      maturity_price = req.price;
      maturity_seen  = 1'b1;
    end
    if (day_idx != DAY_TOP) day_idx++;

    // A run mark without a path end is ignored.
    if (!req.path_end) return 1'b0;

    if (maturity_seen) begin
      up_on   = above_cnt > cfg_act_days;
      down_on = below_cnt > cfg_act_days;
      is_call = maturity_price > cfg_strike;  // a tie with the strike is a zero put
      base    = is_call ? 0 : PUT_BASE;
      amount  = is_call ? maturity_price - cfg_strike : cfg_strike - maturity_price;
      payoff_sum[base + (up_on ? 0 : OUT_OFFSET)] =
          sat_add(payoff_sum[base + (up_on ? 0 : OUT_OFFSET)], amount);
      payoff_sum[base + DOWN_OFFSET + (down_on ? 0 : OUT_OFFSET)] =
          sat_add(payoff_sum[base + DOWN_OFFSET + (down_on ? 0 : OUT_OFFSET)], amount);
    end else begin
      short_path_flag = 1'b1;
    end
    if (path_cnt != PATH_TOP) path_cnt++;
    clear_path_state();

    if (!req.run_end) return 1'b0;

    df_eff = (cfg_discount > pbpa_pkg::DF_ONE) ? pbpa_pkg::DF_ONE : cfg_discount;
    for (int k = 0; k < pbpa_pkg::NUM_SUMS; k++) begin
      mean    = payoff_sum[k] / path_cnt;
      scaled  = mean * df_eff;
      shifted = scaled >> pbpa_pkg::DF_FRAC_BITS;
      rpt.mean_pay[k] = (shifted > {pbpa_pkg::RESULT_BITS{1'b1}}) ?
                        '1 : shifted[pbpa_pkg::RESULT_BITS-1:0];
    end
    rpt.paths      = path_cnt;
    rpt.short_seen = short_path_flag;
    clear_batch_state();
    return 1'b1;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) $display("%0t mismatch: %s", $realtime, what);
  endtask

  // --------------------------------------------------------------------------
  // Sample driver: offers the next pending request at the falling edge once
  // the previous one has gone, idling at random unless the bench is calm.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : feed_samples
    sample_req_t req;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_fire) begin
      if (pending_samples.size() != 0 && (calm || $urandom_range(0, 99) >= 31)) begin
        req = pending_samples.pop_front();
        s_axis_tdata  <= req.price;
        s_axis_tlast  <= req.path_end;
        s_axis_tuser  <= req.run_end;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver: random back-pressure, plus a long freeze on request from
  // the stimulus so that a finished result blocks the next end of run.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : drain_results
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (freeze_seen != freeze_requests) begin
      freeze_seen   <= freeze_requests;
      freeze_left   <= RX_FREEZE_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (freeze_left != 0) begin
      freeze_left   <= freeze_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(0, 99) >= 31);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: everything is sampled at the rising edge. The result side is
  // checked before the predictor takes the sample request of the same edge,
  // so a result can never be matched against its own closing sample.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch_ports
    payoff_report_t got;
    payoff_report_t want;
    payoff_report_t predicted;
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= s_axis_tvalid && s_axis_tready;

      if (m_axis_tvalid && m_axis_tready) begin
        got = payoff_report_t'(m_axis_tdata[REPORT_BITS-1:0]);
        reports_checked++;
        if (expected_reports.size() == 0) begin
          flag_mismatch("result request with no run outstanding");
        end else begin
          want = expected_reports.pop_front();
          for (int k = 0; k < pbpa_pkg::NUM_SUMS; k++) begin
            if (got.mean_pay[k] !== want.mean_pay[k])
              flag_mismatch($sformatf("%s got %08h, expected %08h", sum_names[k],
                                      got.mean_pay[k], want.mean_pay[k]));
          end
          if (got.paths !== want.paths)
            flag_mismatch($sformatf("paths_counted got %0d, expected %0d",
                                    got.paths, want.paths));
          if (got.short_seen !== want.short_seen)
            flag_mismatch($sformatf("short_path_seen got %b, expected %b",
                                    got.short_seen, want.short_seen));
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        samples_taken++;
        if (absorb_sample(sample_req_t'{s_axis_tuser, s_axis_tlast, s_axis_tdata}, predicted))
          expected_reports.push_back(predicted);
      end
    end
  end

  // Watchdog: a hang shows up as a long spell with no request on any port.
  always @(posedge clk) begin : hang_guard
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                 cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("[parisian_barrier_payoff_accumulator_unit] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------

  // Register writes happen only while the block is idle; the predictor copy
  // is updated alongside, masked to the register width.
  task automatic program_register(input pbpa_pkg::cfg_reg_t idx,
                                  input logic [pbpa_pkg::CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      pbpa_pkg::REG_BARRIER_LEVEL:   cfg_barrier    = val[pbpa_pkg::PRICE_BITS-1:0];
      pbpa_pkg::REG_STRIKE_PRICE:    cfg_strike     = val[pbpa_pkg::PRICE_BITS-1:0];
      pbpa_pkg::REG_ACTIVATION_DAYS: cfg_act_days   = val[pbpa_pkg::CFG_DAY_BITS-1:0];
      pbpa_pkg::REG_PAYOFF_DAY:      cfg_payoff_day = val[pbpa_pkg::CFG_DAY_BITS-1:0];
      pbpa_pkg::REG_DISCOUNT_FACTOR: cfg_discount   = val[pbpa_pkg::DF_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [pbpa_pkg::PRICE_BITS-1:0] barrier,
                           input logic [pbpa_pkg::PRICE_BITS-1:0] strike,
                           input int act_days, input int payoff_day,
                           input logic [pbpa_pkg::DF_BITS-1:0] discount);
    program_register(pbpa_pkg::REG_BARRIER_LEVEL, barrier);
    program_register(pbpa_pkg::REG_STRIKE_PRICE, strike);
    program_register(pbpa_pkg::REG_ACTIVATION_DAYS, pbpa_pkg::CFG_DATA_BITS'(act_days));
    program_register(pbpa_pkg::REG_PAYOFF_DAY, pbpa_pkg::CFG_DATA_BITS'(payoff_day));
    program_register(pbpa_pkg::REG_DISCOUNT_FACTOR, pbpa_pkg::CFG_DATA_BITS'(discount));
  endtask

  task automatic push_sample(input logic [pbpa_pkg::PRICE_BITS-1:0] price,
                             input bit eop, input bit eor);
    pending_samples.push_back(sample_req_t'{run_end: eor, path_end: eop, price: price});
  endtask

  // Prices cluster on the barrier and the strike so that ties and near
  // misses on both sides turn up often, with the extremes mixed in.
  function automatic logic [pbpa_pkg::PRICE_BITS-1:0] pick_price();
    case ($urandom_range(0, 9))
      0:       return cfg_barrier;
      1:       return cfg_strike;
      2:       return '0;
      3:       return '1;
      4:       return cfg_barrier + pbpa_pkg::PRICE_BITS'($urandom_range(0, 6)) -
                      pbpa_pkg::PRICE_BITS'(3);
      5:       return cfg_strike + pbpa_pkg::PRICE_BITS'($urandom_range(0, 6)) -
                      pbpa_pkg::PRICE_BITS'(3);
      default: return $urandom;
    endcase
  endfunction

  // One path with random content. A stray run mark now and then lands on a
  // sample that does not end the path, which the block must ignore.
  task automatic queue_path(input int len, input bit closes_run, inout int count);
    for (int i = 0; i < len; i++) begin
      if (i == len - 1) push_sample(pick_price(), 1'b1, closes_run);
      else              push_sample(pick_price(), 1'b0, $urandom_range(0, 15) == 0);
      count++;
    end
  endtask

  task automatic queue_run(input int n_paths, input int max_len, inout int count);
    for (int p = 0; p < n_paths; p++)
      queue_path($urandom_range(1, max_len), p == n_paths - 1, count);
  endtask

  // Waits until every sample request has been taken and every expected
  // result has arrived, then lets the path pipeline drain.
  task automatic settle();
    @(posedge clk);
    wait (pending_samples.size() == 0 && !s_axis_tvalid);
    wait (expected_reports.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin : run_sequence
    int phase;
    int phase_items;
    int random_items;
    int random_runs;
    phase        = 0;
    random_items = 0;
    random_runs  = 0;

    // Register defaults as they come out of reset.
    cfg_barrier    = '0;
    cfg_strike     = '0;
    cfg_act_days   = '0;
    cfg_payoff_day = pbpa_pkg::PAYOFF_DAY_RESET;
    cfg_discount   = pbpa_pkg::DF_ONE;
    clear_path_state();
    clear_batch_state();

    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // With the reset defaults the payoff day is far away, so a one-sample
    // run is a short path and the result is all zero sums.
    push_sample(32'h0001_0000, 1'b1, 1'b1);
    settle();

    // Directed run: ties with barrier and strike, activation on either
    // side, a lone run mark, a short path and a full-strike put.
    configure(32'h0010_0000, 32'h0020_0000, 1, 2, pbpa_pkg::DF_ONE);
    push_sample(32'h0000_0000, 1'b0, 1'b0);
    push_sample(32'h0010_0000, 1'b0, 1'b0);
    push_sample(32'hFFFF_FFFF, 1'b1, 1'b0);
    push_sample(32'h0010_0001, 1'b0, 1'b0);
    push_sample(32'h0010_0002, 1'b0, 1'b0);
    push_sample(32'h0020_0000, 1'b1, 1'b0);
    push_sample(32'h0000_0005, 1'b0, 1'b1);
    push_sample(32'h0000_0007, 1'b1, 1'b0);
    push_sample(32'h0000_0001, 1'b0, 1'b0);
    push_sample(32'h0000_0002, 1'b0, 1'b0);
    push_sample(32'h0000_0000, 1'b0, 1'b0);
    push_sample(32'h0000_0003, 1'b1, 1'b1);
    settle();

    // Opposite register extremes and a discount above one, which the block
    // must clamp to one.
    configure('1, '0, 4095, 0, 17'h1FFFF);
    push_sample(32'hFFFF_FFFF, 1'b1, 1'b1);
    settle();

    // Random runs over a rotating set of register settings. On the second
    // setting the receiver freezes, so the next end of run stalls the input;
    // one later setting runs with no idling on either side.
    while (random_items < RANDOM_TARGET || random_runs < MIN_RANDOM_RUNS) begin
      case (phase % 6)
        0: configure('0, '1, 0, 0, '0);
        1: configure('1, '0, 4095, $urandom_range(0, 5), pbpa_pkg::DF_ONE);
        2: configure($urandom, $urandom, $urandom_range(0, 6), $urandom_range(0, 6),
                     pbpa_pkg::DF_BITS'($urandom_range(0, pbpa_pkg::DF_ONE)));
        3: configure($urandom, $urandom, $urandom_range(0, 6), $urandom_range(0, 6),
                     17'h1FFFF);
        4: configure($urandom, $urandom, $urandom_range(0, 4), $urandom_range(0, 12),
                     pbpa_pkg::DF_BITS'($urandom_range(0, pbpa_pkg::DF_ONE)));
        default: configure($urandom, $urandom, $urandom_range(0, 8), $urandom_range(0, 8),
                           pbpa_pkg::DF_BITS'($urandom_range(0, pbpa_pkg::DF_ONE)));
      endcase
      if (phase == 1) freeze_requests++;
      calm = (phase == CALM_PHASE);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        queue_run($urandom_range(1, 5), 10, phase_items);
        random_runs++;
      end
      random_items += phase_items;
      settle();
      calm = 1'b0;
      phase++;
    end

    $display("Summary: %0d sample requests and %0d results checked, %0d mismatches.",
             samples_taken, reports_checked, mismatch_count);
    $display("Covered register extremes, barrier and strike ties, short paths, stray run %s",
             "marks, discount clamping, a gap-free stretch and a long output stall.");
    if (mismatch_count == 0) begin
      $display("[parisian_barrier_payoff_accumulator_unit] OK");
    end else begin
      $display("[parisian_barrier_payoff_accumulator_unit] ERROR");
    end
    $finish;
  end

endmodule
